[sv/scra_pkg.sv]
`default_nettype none

package scra_pkg;

    // fixed field widths
    localparam int KIND_W       = 2;
    localparam int ROW_IN_W     = 7;
    localparam int COL_IN_W     = 4;
    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int ROW_WIDTH_W  = 5;
    localparam int CFG_ADDR_W   = 4;

    // default store geometry
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_WIDTH = 16;

    // configuration reset values
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 5'd16;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_SRC = 2'd0,
        KIND_LOAD_ACC = 2'd1,
        KIND_APPLY    = 2'd2,
        KIND_READ     = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_MISS_EN   = 2'd1,
        REG_SRC_MISS  = 2'd2,
        REG_ACC_MISS  = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_READ = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[sv/sparse_coo_row_accumulate_top.sv]
`default_nettype none

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------------------
// in        | input     | i_in_valid / o_in_ready   | i_kind i_target_row i_source_row
//           |           |                           | i_column i_data_value
// out       | output    | o_out_valid / i_out_ready | o_read_value o_saturated
// cfg       | input     | psel penable pwrite       | paddr pwdata prdata (pready tied high)
//
// from transfer to result valid, a load or an ignored apply goes straight to the finish state, a read
// passes the read state first, and an apply first runs the one-column-per-cycle read-modify-write walk
// over the accumulator memory (read, multiply stage, add and saturate with write-back).
// one item is in flight at a time; the input is ready again as the result is loaded,
// and an item whose result cannot be loaded yet waits at the end of its walk.
// reset is synchronous, active low, and clears control and configuration, not memories.

module sparse_coo_row_accumulate_top #(
    parameter int MAX_ROWS  = scra_pkg::DEF_MAX_ROWS,
    parameter int MAX_WIDTH = scra_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [scra_pkg::KIND_W-1:0]            i_kind,
    input  wire logic [scra_pkg::ROW_IN_W-1:0]          i_target_row,
    input  wire logic [scra_pkg::ROW_IN_W-1:0]          i_source_row,
    input  wire logic [scra_pkg::COL_IN_W-1:0]          i_column,
    input  wire logic signed [scra_pkg::DATA_W-1:0]     i_data_value,
    // output channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [scra_pkg::DATA_W-1:0]          o_read_value,
    output logic                                        o_saturated,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [scra_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);

    localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int DW     = scra_pkg::DATA_W;
    localparam int FW     = scra_pkg::FRAC_W;
    localparam int PROD_W = 2 * DW;
    localparam int SUM_W  = PROD_W - FW + 1;

    // configuration registers
    logic [scra_pkg::ROW_WIDTH_W-1:0] r_row_width;
    logic                             r_miss_en;
    logic [DW-1:0]                    r_src_miss;
    logic [DW-1:0]                    r_acc_miss;
    logic                             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= scra_pkg::ROW_WIDTH_RST;
            r_miss_en   <= 1'b0;
            r_src_miss  <= '0;
            r_acc_miss  <= '0;
        end else if (cfg_wr) begin
            case (scra_pkg::t_reg_idx'(paddr[3:2]))
                scra_pkg::REG_ROW_WIDTH: r_row_width <= pwdata[scra_pkg::ROW_WIDTH_W-1:0];
                scra_pkg::REG_MISS_EN:   r_miss_en   <= pwdata[0];
                scra_pkg::REG_SRC_MISS:  r_src_miss  <= pwdata;
                scra_pkg::REG_ACC_MISS:  r_acc_miss  <= pwdata;
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (scra_pkg::t_reg_idx'(paddr[3:2]))
            scra_pkg::REG_ROW_WIDTH: prdata = 32'(r_row_width);
            scra_pkg::REG_MISS_EN:   prdata = 32'(r_miss_en);
            scra_pkg::REG_SRC_MISS:  prdata = r_src_miss;
            scra_pkg::REG_ACC_MISS:  prdata = r_acc_miss;
            default:                 prdata = '0;
        endcase
    end

    // sequencer and walk state
    scra_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_w;
    logic [ADDR_W-1:0] r_saddr;
    logic [ADDR_W-1:0] r_taddr;
    logic [DW-1:0]     r_coef;
    logic              r_rd_ok;
    logic [DW-1:0]     r_res;
    logic              r_sat;

    // pipeline registers of the walk
    logic              r_s1_v;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_v;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [PROD_W-1:0] r_prod;
    logic [DW-1:0]     r_s2_acc;
    logic              r_s2_miss;

    // memories and their registered read data
    logic [DW-1:0]     r_src_mem [DEPTH];
    logic [DW-1:0]     r_acc_mem [DEPTH];
    logic [DW-1:0]     r_src_rd;
    logic [DW-1:0]     r_acc_rd;

    // output register
    logic              r_out_valid;
    logic [DW-1:0]     r_out_value;
    logic              r_out_sat;

    // input decode
    logic              in_xfer;
    logic              trow_ok, srow_ok, col_ok;
    logic [ADDR_W-1:0] in_tbase, in_sbase;
    logic [ADDR_W-1:0] in_taddr, in_saddr;
    logic [CNT_W-1:0]  in_w;
    logic              issue;
    logic              walk_done;
    logic              out_free;

    assign o_in_ready = (r_state == scra_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    assign trow_ok = (i_target_row != '0) && (32'(i_target_row) <= 32'(MAX_ROWS));
    assign srow_ok = (i_source_row != '0) && (32'(i_source_row) <= 32'(MAX_ROWS));
    assign col_ok  = 32'(i_column) < 32'(MAX_WIDTH);

    // row base is (row - 1) * MAX_WIDTH
    assign in_tbase = ADDR_W'(32'(i_target_row - 7'd1) * 32'(MAX_WIDTH));
    assign in_sbase = ADDR_W'(32'(i_source_row - 7'd1) * 32'(MAX_WIDTH));
    assign in_taddr = in_tbase + ADDR_W'(i_column);
    assign in_saddr = in_sbase + ADDR_W'(i_column);

    // clamp row_width to the store width
    assign in_w = (32'(r_row_width) > 32'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                       : CNT_W'(r_row_width);

    assign issue     = (r_state == scra_pkg::ST_RUN) && (r_cnt != r_w);
    assign walk_done = (r_cnt == r_w) && !r_s1_v && !r_s2_v;
    assign out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scra_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (scra_pkg::t_kind'(i_kind))
                        scra_pkg::KIND_APPLY: begin
                            if (trow_ok && srow_ok && (in_w != '0)) begin
                                n_state = scra_pkg::ST_RUN;
                            end else begin
                                n_state = scra_pkg::ST_FIN;
                            end
                        end
                        scra_pkg::KIND_READ: n_state = scra_pkg::ST_READ;
                        default:             n_state = scra_pkg::ST_FIN;
                    endcase
                end
            end
            scra_pkg::ST_RUN: begin
                if (walk_done) begin
                    n_state = scra_pkg::ST_FIN;
                end
            end
            scra_pkg::ST_READ: n_state = scra_pkg::ST_FIN;
            scra_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = scra_pkg::ST_IDLE;
                end
            end
            default: n_state = scra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item capture and column walk
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_coef  <= i_data_value;
            r_saddr <= in_sbase;
            r_taddr <= in_tbase;
            r_w     <= in_w;
            r_cnt   <= '0;
            r_rd_ok <= trow_ok && col_ok;
        end else if (issue) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_saddr <= r_saddr + ADDR_W'(1);
            r_taddr <= r_taddr + ADDR_W'(1);
        end
    end

    // result of the item, zero for all kinds but a read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= '0;
        end else if (r_state == scra_pkg::ST_READ) begin
            r_res <= r_rd_ok ? r_acc_rd : '0;
        end
    end

    // source memory: load writes, walk reads
    always_ff @(posedge i_clk) begin
        if (in_xfer && (scra_pkg::t_kind'(i_kind) == scra_pkg::KIND_LOAD_SRC)
                && srow_ok && col_ok) begin
            r_src_mem[in_saddr] <= i_data_value;
        end
        r_src_rd <= r_src_mem[r_saddr];
    end

    // accumulator memory: one write port (load or write-back), one read port
    logic              acc_we;
    logic [ADDR_W-1:0] acc_waddr;
    logic [DW-1:0]     acc_wdata;
    logic [ADDR_W-1:0] acc_raddr;
    logic              ld_acc;

    assign ld_acc    = in_xfer && (scra_pkg::t_kind'(i_kind) == scra_pkg::KIND_LOAD_ACC)
                       && trow_ok && col_ok;
    assign acc_raddr = (r_state == scra_pkg::ST_IDLE) ? in_taddr : r_taddr;

    // saturating add of the truncated product; columns within one walk never repeat,
    // so the write-back never meets a read of the same entry in flight
    logic [SUM_W-1:0] sum;
    logic             ovf_pos, ovf_neg;
    logic [DW-1:0]    sum_sat;

    assign sum     = {{(SUM_W-DW){r_s2_acc[DW-1]}}, r_s2_acc}
                   + {r_prod[PROD_W-1], r_prod[PROD_W-1:FW]};
    assign ovf_pos = !sum[SUM_W-1] && (|sum[SUM_W-2:DW-1]);
    assign ovf_neg = sum[SUM_W-1] && !(&sum[SUM_W-2:DW-1]);
    assign sum_sat = ovf_pos ? {1'b0, {(DW-1){1'b1}}}
                   : ovf_neg ? {1'b1, {(DW-1){1'b0}}}
                   : sum[DW-1:0];

    always_comb begin
        acc_we    = ld_acc || r_s2_v;
        acc_waddr = r_s2_v ? r_s2_addr : in_taddr;
        acc_wdata = r_s2_v ? (r_s2_miss ? r_acc_miss : sum_sat) : i_data_value;
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_rd <= r_acc_mem[acc_raddr];
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
        end
    end

    // multiply stage and missing-value test
    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_taddr;
        r_s2_addr <= r_s1_addr;
        r_prod    <= PROD_W'($signed(r_coef) * $signed(r_src_rd));
        r_s2_acc  <= r_acc_rd;
        r_s2_miss <= r_miss_en && ((r_src_rd == r_src_miss) || (r_acc_rd == r_acc_miss));
    end

    // sticky saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (r_s2_v && !r_s2_miss && (ovf_pos || ovf_neg)) begin
            r_sat <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == scra_pkg::ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == scra_pkg::ST_FIN) && out_free) begin
            r_out_value <= r_res;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_saturated  = r_out_sat;

    // checks
    a_s2_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == scra_pkg::ST_RUN))
        else $error("write-back stage active outside the walk");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scra_pkg::ST_RUN) |-> (r_cnt <= r_w))
        else $error("column count past row width");

    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != scra_pkg::ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |=> r_sat)
        else $error("saturation flag cleared");

endmodule

`default_nettype wire
